// ===== rtl/kpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kpt_pkg;

  localparam int unsigned NumKeys = 16;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned CodeW   = 7;
  localparam int unsigned CntW    = 5;

  // ASCII codes, indexed by row*4+col
  localparam logic [CodeW-1:0] KeyTab [NumKeys] = '{
    7'h44, 7'h23, 7'h30, 7'h2A,   // D # 0 *
    7'h43, 7'h39, 7'h38, 7'h37,   // C 9 8 7
    7'h42, 7'h36, 7'h35, 7'h34,   // B 6 5 4
    7'h41, 7'h33, 7'h32, 7'h31    // A 3 2 1
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } kpt_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } kpt_cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_busy;
  } kpt_sts_t;

  // bit index is col*4+row; table is row-major
  function automatic logic [CodeW-1:0] kpt_code(input logic [IdxW-1:0] bit_idx);
    return KeyTab[{bit_idx[1:0], bit_idx[3:2]}];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kpt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kpt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pressed_now;

  modport source (output valid, output pressed_now, input ready);
  modport sink (input valid, input pressed_now, output ready);
endinterface

interface kpt_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  key_code;
  logic [4:0]  down_count;
  logic [15:0] down_map;

  modport source (output valid, output key_code, output down_count, output down_map,
                  input ready);
  modport sink (input valid, input key_code, input down_count, input down_map,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/kpt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpt_ctrl
  import kpt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire kpt_sts_t sts_i,
  output kpt_cmd_t      cmd_o
);

  kpt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_step) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/kpt_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpt_dpath
  import kpt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] pressed_now_i,
  input  wire kpt_cmd_t    cmd_i,
  output kpt_sts_t         sts_o,
  kpt_out_if.source        out_o
);

  logic [NumKeys-1:0] scan_q;
  logic [NumKeys-1:0] map_q, map_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CodeW-1:0]   last_q;
  logic [CodeW-1:0]   sel_q, sel_d;
  logic [IdxW-1:0]    idx_q;

  logic               out_valid_q;
  logic [CodeW-1:0]   out_code_q;
  logic [CntW-1:0]    out_cnt_q;
  logic [NumKeys-1:0] out_map_q;

  logic               now_bit, was_bit;
  logic [NumKeys-1:0] rel_map;
  logic [IdxW-1:0]    other_idx;
  logic [CodeW-1:0]   other_code;

  assign now_bit = scan_q[idx_q];
  assign was_bit = map_q[idx_q];

  // map as it stands if the current key is released
  assign rel_map = map_q & ~(NumKeys'(1) << idx_q);

  // after a release that leaves one key, rel_map is one-hot: encode its index
  always_comb begin
    other_idx = '0;
    for (int k = 0; k < NumKeys; k++) begin
      if (rel_map[k]) begin
        other_idx = other_idx | IdxW'(k);
      end
    end
  end

  assign other_code = kpt_code(other_idx);

  always_comb begin
    map_d = map_q;
    cnt_d = cnt_q;
    sel_d = sel_q;
    if (now_bit && !was_bit) begin
      map_d[idx_q] = 1'b1;
      cnt_d        = cnt_q + CntW'(1);
      if (cnt_q == CntW'(0)) begin
        sel_d = kpt_code(idx_q);
      end
    end else if (!now_bit && was_bit) begin
      map_d[idx_q] = 1'b0;
      cnt_d        = cnt_q - CntW'(1);
      if (cnt_q == CntW'(2) && other_code != last_q) begin
        sel_d = other_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= '0;
      cnt_q  <= '0;
      last_q <= '0;
      idx_q  <= '0;
      sel_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
        sel_q <= '0;
      end else if (cmd_i.step) begin
        map_q <= map_d;
        cnt_q <= cnt_d;
        sel_q <= sel_d;
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.commit && (sel_q != '0 || cnt_q == '0)) begin
        last_q <= sel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      scan_q <= pressed_now_i;
    end
    if (cmd_i.commit) begin
      out_code_q <= sel_q;
      out_cnt_q  <= cnt_q;
      out_map_q  <= map_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.last_step = (idx_q == IdxW'(NumKeys - 1));
  assign sts_o.out_busy  = out_valid_q && !out_o.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.key_code   = out_code_q;
  assign out_o.down_count = out_cnt_q;
  assign out_o.down_map   = out_map_q;

endmodule

`default_nettype wire

// ===== rtl/keypad_press_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each input item is accepted in ST_IDLE, scanned in ST_SCAN and committed in ST_FINISH;
// the 16 keys are stepped one per cycle through a single compare/update stage, and the
// commit waits while the output register is busy. A new item is taken only back in ST_IDLE.
// An input item is taken while the previous result still waits in the output register.
// Reset (async, active low) clears the held-key map, count and last reported key.

module keypad_press_tracker_unit
  import kpt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kpt_in_if.sink    in_i,
  kpt_out_if.source out_o
);

  kpt_cmd_t cmd;
  kpt_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  kpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kpt_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pressed_now_i (in_i.pressed_now),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_o         (out_o)
  );

endmodule

`default_nettype wire
